// ===== src/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent after the delay given by n
`define ASSERT_DELAY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== src/gb5_pkg.sv =====
package gb5_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int KERNEL_SIZE   = 5;
  localparam int LINES         = KERNEL_SIZE - 1;
  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int FW_W          = 12;
  localparam int FH_W          = 13;
  localparam int OUT_ROW_W     = 12;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam int REG_SEL_BIT   = 2;
  localparam int FIFO_DEPTH    = 8;
  localparam int HSUM_W        = 12;
  localparam int VSUM_W        = 16;

  localparam logic [FW_W-1:0] WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RST = FH_W'(480);

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [LINES*PIX_W-1:0] line_word_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } tag_t;

  typedef struct packed {
    logic   last;
    pixel_t px;
  } res_t;

  // 1 4 6 4 1 weighted sum of five values
  function automatic logic [VSUM_W-1:0] binom5(input logic [VSUM_W-1:0] a,
                                                input logic [VSUM_W-1:0] b,
                                                input logic [VSUM_W-1:0] c,
                                                input logic [VSUM_W-1:0] d,
                                                input logic [VSUM_W-1:0] e);
    logic [VSUM_W-1:0] s;
    s = a + e + ((b + d) << 2) + (c << 2) + (c << 1);
    return s;
  endfunction

endpackage

// ===== src/gb5_ram.sv =====
module gb5_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/gb5_fifo.sv =====
module gb5_fifo #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop_ready,
  output logic                       pop_valid,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             pop;

  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;
  assign full      = (count_r == NW'(DEPTH));
  assign pop       = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/gb5_ctrl.sv =====
module gb5_ctrl import gb5_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_AW-1:0]            paddr,
  input  logic [CFG_DW-1:0]            pwdata,
  output logic [CFG_DW-1:0]            prdata,
  input  logic                         item_acc,
  input  logic                         item_flush,
  input  pixel_t                       item_px,
  output logic                         take,
  output logic [$clog2(MAX_WIDTH)-1:0] take_col,
  output pixel_t                       take_px,
  output tag_t                         take_tag
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EW  = $clog2(MAX_WIDTH + 1);
  localparam int EW1 = EW + 1;
  localparam int DW  = EW + 2;

  logic [FW_W-1:0]      fw_r, fw_nxt;
  logic [FH_W-1:0]      fh_r, fh_nxt;
  logic [CW-1:0]        in_col_r, in_col_nxt;
  logic [FH_W-1:0]      in_row_r, in_row_nxt;
  logic [CW-1:0]        out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [DW-1:0]        diff_r, diff_nxt;

  logic [EW-1:0]   eff_w;
  logic [FH_W-1:0] eff_h;
  logic            input_done;
  logic            in_wrap;
  logic            out_wrap;
  logic [DW-1:0]   diff_inc;
  logic [DW-1:0]   delay;
  logic            emit;
  logic            col_ok;
  logic            row_ok;
  logic            last;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  // zero means one, oversize saturates
  assign eff_w = (fw_r == '0) ? EW'(1) :
                 (32'(fw_r) > 32'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(fw_r);
  assign eff_h = (fh_r == '0) ? FH_W'(1) :
                 (fh_r > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_r;

  assign input_done = (in_row_r >= eff_h);
  assign take       = item_acc & (input_done | ~item_flush);
  assign take_px    = input_done ? '0 : item_px;
  assign take_col   = in_col_r;

  assign in_wrap  = (EW'(in_col_r) == eff_w - EW'(1));
  assign out_wrap = (EW'(out_col_r) == eff_w - EW'(1));

  // distance between input and output positions replaces two products
  assign diff_inc = diff_r + DW'(1);
  assign delay    = (DW'(eff_w) << 1) + DW'(2);
  assign emit     = take & (diff_inc > delay);

  assign col_ok = (out_col_r >= CW'(2)) && ((EW1'(out_col_r) + EW1'(2)) < EW1'(eff_w));
  assign row_ok = (out_row_r >= OUT_ROW_W'(2)) && ((FH_W'(out_row_r) + FH_W'(2)) < eff_h);
  assign last   = out_wrap && (FH_W'(out_row_r) == eff_h - FH_W'(1));

  assign take_tag = '{emit: emit, border: ~(col_ok & row_ok), last: last};

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[REG_SEL_BIT]);

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DW'(fw_r);
      REG_FRAME_HEIGHT: prdata = CFG_DW'(fh_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    fw_nxt      = fw_r;
    fh_nxt      = fh_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    diff_nxt    = diff_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  fw_nxt = pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_nxt = pwdata[FH_W-1:0];
        default:          ;
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      diff_nxt    = '0;
    end else if (take) begin
      if (in_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + FH_W'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (!emit) begin
        diff_nxt = diff_inc;
      end else if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        diff_nxt    = '0;
      end else if (out_wrap) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + OUT_ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= WIDTH_RST;
      fh_r      <= HEIGHT_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      diff_r    <= '0;
    end else begin
      fw_r      <= fw_nxt;
      fh_r      <= fh_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      diff_r    <= diff_nxt;
    end
  end

endmodule

// ===== src/gb5_kernel.sv =====
module gb5_kernel import gb5_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  pixel_t [KERNEL_SIZE-1:0]     col_in,
  input  tag_t                         tag_in,
  output logic                         res_valid,
  output res_t                         res_data,
  output logic [1:0]                   busy
);

  // window rows: 0 oldest line .. 4 newest, columns: 0 oldest .. 4 newest
  pixel_t              win_r [KERNEL_SIZE][KERNEL_SIZE];
  logic                s2_valid_r;
  tag_t                s2_tag_r;
  logic                s3_valid_r;
  tag_t                s3_tag_r;
  pixel_t              center_r;
  logic [HSUM_W-1:0]   hs_r [KERNEL_SIZE][3];
  logic [HSUM_W-1:0]   hs   [KERNEL_SIZE][3];
  logic [VSUM_W-1:0]   vs   [3];
  pixel_t              blur;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
          win_r[j][i] <= win_r[j][i+1];
        end
        win_r[j][KERNEL_SIZE-1] <= col_in[j];
      end
    end
  end

  // horizontal pass, one weighted sum per row and channel
  always_comb begin
    for (int j = 0; j < KERNEL_SIZE; j++) begin
      for (int c = 0; c < 3; c++) begin
        hs[j][c] = HSUM_W'(binom5(VSUM_W'(win_r[j][0][c*CH_W +: CH_W]),
                                  VSUM_W'(win_r[j][1][c*CH_W +: CH_W]),
                                  VSUM_W'(win_r[j][2][c*CH_W +: CH_W]),
                                  VSUM_W'(win_r[j][3][c*CH_W +: CH_W]),
                                  VSUM_W'(win_r[j][4][c*CH_W +: CH_W])));
      end
    end
  end

  always_ff @(posedge clk) begin
    hs_r     <= hs;
    center_r <= win_r[2][2];
    s2_tag_r <= tag_in;
    s3_tag_r <= s2_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= shift_en & tag_in.emit;
      s3_valid_r <= s2_valid_r;
    end
  end

  // vertical pass, total weight 256
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vs[c] = binom5(VSUM_W'(hs_r[0][c]), VSUM_W'(hs_r[1][c]), VSUM_W'(hs_r[2][c]),
                     VSUM_W'(hs_r[3][c]), VSUM_W'(hs_r[4][c]));
      blur[c*CH_W +: CH_W] = vs[c][VSUM_W-1 -: CH_W];
    end
  end

  assign res_valid   = s3_valid_r;
  assign res_data.last = s3_tag_r.last;
  assign res_data.px   = s3_tag_r.border ? center_r : blur;
  assign busy        = {s3_valid_r, s2_valid_r};

endmodule

// ===== src/gaussian_blur_5x5_rgb.sv =====
// 5x5 binomial blur (weights 1 4 6 4 1 per axis, sum divided by 256) on an rgb raster stream
// in_*: one pixel per item, in_tdata = red, green, blue from bit 0 up; in_tuser marks a
//   flush item, which is dropped before the frame's last pixel and pushes out the tail after it
// out_*: one result per position in raster order, out_tlast on the frame's last position
// the result for position p leaves with the item for position p + 2*width + 2, so a frame
//   needs 2*width + 2 flush items behind it; the two-pixel border passes through unchanged
// frame size comes from the apb registers (width at 0x0, height at 0x4); a write restarts
//   the frame counters and must only happen while the block is idle
// throughput: one item per clock while in_tready is high, set by the single read-modify-write of the
//   line store per column (four lines packed in one word); an accepted item passes the write-back
//   stage, the kernel stages s2 and s3 and the output queue before its result shows on out_tvalid
// the output queue holds eight results and in_tready only depends on room in it, so the
//   input keeps flowing while a result waits; a stalled receiver stops input once in-flight
//   results would fill the queue
// reset: counters clear and the size returns to 640 x 480; the line store is not cleared,
//   its stale words only reach window cells that no blurred result uses
`include "assert_macros.svh"

module gaussian_blur_5x5_rgb import gb5_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: in_red [7:0], in_green [15:8], in_blue [23:16]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,
  // in_tuser: flush
  input  logic              in_tuser,
  // out_tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,
  output logic              out_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  // accept side
  logic          in_acc;
  logic          take;
  logic [CW-1:0] take_col;
  pixel_t        take_px;
  tag_t          take_tag;

  // write-back stage, in the cycle after the line store read
  logic          s1_valid_r;
  logic [CW-1:0] s1_col_r;
  pixel_t        s1_px_r;
  tag_t          s1_tag_r;
  line_word_t    ram_rdata;
  line_word_t    lines_q;
  line_word_t    wr_word;
  logic          fwd_r, fwd_nxt;
  line_word_t    fwd_data_r;
  tag_t          kern_tag;

  pixel_t [KERNEL_SIZE-1:0] col_vec;

  logic          res_valid;
  res_t          res_data;
  res_t          q_data;
  logic [1:0]    kern_busy;
  logic [NW-1:0] q_count;
  logic          q_full;
  logic [NW:0]   reserved;

  assign pready = 1'b1;
  assign in_acc = in_tvalid & in_tready;

  gb5_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .item_acc  (in_acc),
    .item_flush(in_tuser),
    .item_px   (in_tdata),
    .take      (take),
    .take_col  (take_col),
    .take_px   (take_px),
    .take_tag  (take_tag)
  );

  // four earlier lines of one column in one word, line 0 newest in the low bits
  gb5_ram #(
    .WIDTH($bits(line_word_t)),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (s1_valid_r),
    .wr_addr(s1_col_r),
    .wr_data(wr_word),
    .rd_en  (take),
    .rd_addr(take_col),
    .rd_data(ram_rdata)
  );

  // a width of one reads the column that is being written back in the same clock
  assign lines_q = fwd_r ? fwd_data_r : ram_rdata;
  assign wr_word = {lines_q[(LINES-1)*PIX_W-1:0], s1_px_r};
  assign fwd_nxt = take & s1_valid_r & (s1_col_r == take_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= take;
      fwd_r      <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col_r   <= take_col;
      s1_px_r    <= take_px;
      s1_tag_r   <= take_tag;
      fwd_data_r <= wr_word;
    end
  end

  // window column: oldest line on row 0, the new pixel on row 4
  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      col_vec[LINES-1-k] = lines_q[k*PIX_W +: PIX_W];
    end
    col_vec[KERNEL_SIZE-1] = s1_px_r;
  end

  assign kern_tag = '{emit: s1_valid_r & s1_tag_r.emit, border: s1_tag_r.border,
                      last: s1_tag_r.last};

  gb5_kernel u_kernel (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_valid_r),
    .col_in   (col_vec),
    .tag_in   (kern_tag),
    .res_valid(res_valid),
    .res_data (res_data),
    .busy     (kern_busy)
  );

  gb5_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res_data),
    .pop_ready(out_tready),
    .pop_valid(out_tvalid),
    .pop_data (q_data),
    .count    (q_count),
    .full     (q_full)
  );

  assign out_tdata = q_data.px;
  assign out_tlast = q_data.last;

  // queue slots plus results still in the pipeline must leave room for one more
  assign reserved  = (NW+1)'(q_count) + (NW+1)'(kern_tag.emit) + (NW+1)'(kern_busy[0])
                   + (NW+1)'(kern_busy[1]);
  assign in_tready = (reserved < (NW+1)'(FIFO_DEPTH));

  `ASSERT_IMPLIES(a_queue_no_overflow, res_valid, !q_full, "result pushed into a full queue")
  `ASSERT_DELAY(a_result_latency, kern_tag.emit, 2, res_valid, "result lost in the kernel")
  `ASSERT_IMPLIES(a_fwd_live, fwd_r, s1_valid_r, "forwarded word without a write-back item")

endmodule
